// File: rtl/bpf_pkg.sv
package bpf_pkg;

	// Framing bytes
	localparam logic [7:0] BYTE_START = 8'h01;
	localparam logic [7:0] BYTE_STOP  = 8'h17;

	// Byte slot of the packet being emitted
	typedef enum logic [2:0] {
		PH_START,
		PH_CMD,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_DATA,
		PH_CHK_LO,
		PH_CHK_HI,
		PH_STOP
	} phase_t;

	// Sequencer to checksum unit
	typedef struct packed {
		logic seed;    // load the mode's initial value before absorbing
		logic absorb;  // fold byte_in into the accumulator
		logic clear;   // packet closed
	} chk_ctl_t;

endpackage

// File: rtl/bootloader_packet_framer_top.sv
// Bootloader packet framer. Each begin transfer (op 0) produces the header
// 0x01, command, length low, length high; each data transfer (op 1) produces
// its byte. After the last payload byte, or straight after the header when
// the length is zero, the checksum low byte, checksum high byte and stop
// byte 0x17 follow. One output transfer carries one byte, so a begin gives
// 4 bytes (7 with a zero length), a data byte 1 (4 when it closes the
// packet) and a stray data byte 1 with frame_error set. The checksum is
// folded in one byte per cycle as bytes leave, while the output is not
// stalled, so payload is never stored. Lengths above MAX_PAYLOAD are
// clipped and the header carries the clipped value.
// A begin while a packet is open drops that packet without a trailer.
// checksum_mode (cfg_data) should only be written while the block is idle.
module bootloader_packet_framer_top
	import bpf_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = 512
)
(
	input  logic       clk,
	input  logic       arst_n,

	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,

	input  logic       in_valid,
	output logic       in_ready,
	input  logic       op,
	input  logic [7:0] command,
	input  logic [9:0] length,
	input  logic [7:0] data_byte,

	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       packet_end,
	output logic       run_last,
	output logic       frame_error
);

	// checksum mode register
	logic mode_q;

	// input register: one item waits here while its bytes go out
	logic       item_valid_q;
	logic       item_op_q;
	logic [7:0] item_cmd_q;
	logic [9:0] item_len_q;
	logic [7:0] item_dat_q;

	// packet state
	logic       busy_q;    // item part way through its bytes
	phase_t     phase_q;
	logic [9:0] bytes_left_q;
	logic       open_q;

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_end_q;
	logic       out_last_q;
	logic       out_err_q;

	logic        in_xfer;
	logic        adv;
	logic        fire;
	logic        len_over;
	logic [9:0]  len_sat;
	phase_t      cur_phase;
	phase_t      nxt_phase;
	logic        data_err;
	logic        item_last;
	logic [7:0]  emit_byte;
	logic        emit_end;
	logic        emit_err;
	chk_ctl_t    chk_ctl;
	logic [15:0] chk_word;

	// config is always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	// clip the length on the way in
	assign len_over = {7'b0, length} > 17'(MAX_PAYLOAD);
	assign len_sat  = len_over ? 10'(MAX_PAYLOAD) : length;

	// the output stage moves when empty or drained this cycle
	assign adv       = !out_valid_q || out_ready;
	assign fire      = item_valid_q && adv;
	assign in_ready  = !item_valid_q || (fire && item_last);
	assign in_xfer   = in_valid && in_ready;

	assign cur_phase = busy_q ? phase_q : (item_op_q ? PH_DATA : PH_START);
	assign data_err  = !open_q || (bytes_left_q == 10'd0);

	// next state
	always_comb begin
		nxt_phase = cur_phase;
		item_last = 1'b0;
		case (cur_phase)
			PH_START:  nxt_phase = PH_CMD;
			PH_CMD:    nxt_phase = PH_LEN_LO;
			PH_LEN_LO: nxt_phase = PH_LEN_HI;
			PH_LEN_HI: begin
				if (item_len_q == 10'd0) begin
					nxt_phase = PH_CHK_LO;
				end else begin
					item_last = 1'b1;
				end
			end
			PH_DATA: begin
				if (!data_err && bytes_left_q == 10'd1) begin
					nxt_phase = PH_CHK_LO;
				end else begin
					item_last = 1'b1;
				end
			end
			PH_CHK_LO: nxt_phase = PH_CHK_HI;
			PH_CHK_HI: nxt_phase = PH_STOP;
			PH_STOP:   item_last = 1'b1;
			default:   item_last = 1'b1;
		endcase
	end

	// outputs of the current slot
	always_comb begin
		emit_byte = 8'h00;
		emit_end  = 1'b0;
		emit_err  = 1'b0;
		chk_ctl   = '0;
		case (cur_phase)
			PH_START: begin
				emit_byte      = BYTE_START;
				chk_ctl.seed   = fire;
				chk_ctl.absorb = fire;
			end
			PH_CMD: begin
				emit_byte      = item_cmd_q;
				chk_ctl.absorb = fire;
			end
			PH_LEN_LO: begin
				emit_byte      = item_len_q[7:0];
				chk_ctl.absorb = fire;
			end
			PH_LEN_HI: begin
				emit_byte      = {6'b0, item_len_q[9:8]};
				chk_ctl.absorb = fire;
			end
			PH_DATA: begin
				emit_err       = data_err;
				emit_byte      = data_err ? 8'h00 : item_dat_q;
				chk_ctl.absorb = fire && !data_err;
			end
			PH_CHK_LO: emit_byte = chk_word[7:0];
			PH_CHK_HI: emit_byte = chk_word[15:8];
			PH_STOP: begin
				emit_byte     = BYTE_STOP;
				emit_end      = 1'b1;
				chk_ctl.clear = fire;
			end
			default: emit_byte = 8'h00;
		endcase
	end

	// begin: byte 0x01 seeds and absorbs in the same cycle
	bpf_chk u_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.ctl      (chk_ctl),
		.byte_in  (emit_byte),
		.chk_word (chk_word)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_q <= 1'b0;
		end else if (in_xfer) begin
			item_valid_q <= 1'b1;
		end else if (fire && item_last) begin
			item_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_op_q  <= op;
			item_cmd_q <= command;
			item_len_q <= len_sat;
			item_dat_q <= data_byte;
		end
	end

	// sequencer and packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			phase_q      <= PH_START;
			bytes_left_q <= '0;
			open_q       <= 1'b0;
		end else if (fire) begin
			busy_q  <= !item_last;
			phase_q <= nxt_phase;
			if (cur_phase == PH_START) begin
				open_q       <= 1'b1;
				bytes_left_q <= item_len_q;
			end else if (cur_phase == PH_DATA && !data_err) begin
				bytes_left_q <= bytes_left_q - 10'd1;
			end else if (cur_phase == PH_STOP) begin
				open_q       <= 1'b0;
				bytes_left_q <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q <= emit_byte;
			out_end_q  <= emit_end;
			out_last_q <= item_last;
			out_err_q  <= emit_err;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign packet_end  = out_end_q;
	assign run_last    = out_last_q;
	assign frame_error = out_err_q;

endmodule

// File: rtl/bpf_chk.sv
module bpf_chk
	import bpf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        mode,
	input  chk_ctl_t    ctl,
	input  logic [7:0]  byte_in,
	output logic [15:0] chk_word
);

	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [15:0] CRC_SEED = 16'hFFFF;

	logic [15:0] accum_q;
	logic [15:0] base;
	logic [15:0] upd;
	logic [15:0] inv;

	// reflected CRC, one byte, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c;
		for (int i = 0; i < 8; i++) begin
			if (r[0] ^ b[i]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	always_comb begin
		if (ctl.seed) begin
			base = mode ? CRC_SEED : 16'h0000;
		end else begin
			base = accum_q;
		end
		if (mode) begin
			upd = crc_byte(base, byte_in);
		end else begin
			upd = base + {8'h00, byte_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
		end else if (ctl.clear) begin
			accum_q <= '0;
		end else if (ctl.absorb) begin
			accum_q <= upd;
		end else if (ctl.seed) begin
			accum_q <= base;
		end
	end

	// trailer value: negated sum, or inverted CRC with bytes swapped
	assign inv      = ~accum_q;
	assign chk_word = mode ? {inv[7:0], inv[15:8]} : (16'h0000 - accum_q);

endmodule

// File: dv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bpf_pkg::*;

	// Payload clip of the block under test; passed down so both sides agree
	localparam int unsigned MAX_LEN = 512;

	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [15:0] CRC_SEED = 16'hFFFF;

	// checksum_mode values
	localparam bit MODE_SUM = 1'b0;
	localparam bit MODE_CRC = 1'b1;

	// Cycles without any transfer on any channel before the run is abandoned.
	// Longest legitimate quiet stretch is the long receiver hold-off.
	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_CYCLES = 90;

	typedef enum logic {
		OP_BEGIN = 1'b0,
		OP_DATA  = 1'b1
	} frame_op_t;

	// One byte of the output stream as it should appear
	typedef struct packed {
		logic [7:0] value;
		logic       pkt_end;
		logic       last;
		logic       err;
	} frame_byte_t;

	// Tracks framer state and holds the bytes still owed by the block.
	class frame_tracker;
		bit          mode;
		logic [9:0]  left;
		logic [15:0] accum;
		bit          open;
		frame_byte_t owed_bytes[$];
		int          errors;

		function void fold(logic [7:0] b);
			logic [7:0] v;
			v = b;
			if (mode == MODE_SUM) begin
				accum = accum + 16'(v);
				return;
			end
			for (int i = 0; i < 8; i++) begin
				if (accum[0] ^ v[0])
					accum = (accum >> 1) ^ CRC_POLY;
				else
					accum = accum >> 1;
				v = v >> 1;
			end
		endfunction

		function void owe(logic [7:0] value, logic pkt_end, logic err);
			frame_byte_t fb;
			fb.value   = value;
			fb.pkt_end = pkt_end;
			fb.last    = 1'b0;
			fb.err     = err;
			owed_bytes.push_back(fb);
		endfunction

		function void close_packet();
			logic [15:0] chk;
			logic [15:0] inv;
			inv = ~accum;
			if (mode == MODE_SUM)
				chk = 16'h0000 - accum;
			else
				chk = {inv[7:0], inv[15:8]};
			owe(chk[7:0], 1'b0, 1'b0);
			owe(chk[15:8], 1'b0, 1'b0);
			owe(BYTE_STOP, 1'b1, 1'b0);
			open  = 1'b0;
			left  = '0;
			accum = '0;
		endfunction

		// Called on every accepted input transfer
		function void take_item(frame_op_t op, logic [7:0] cmd, logic [9:0] len,
				logic [7:0] dat);
			frame_byte_t tail;
			if (op == OP_BEGIN) begin
				if (len > MAX_LEN)
					len = 10'(MAX_LEN);
				accum = (mode == MODE_SUM) ? 16'h0000 : CRC_SEED;
				open  = 1'b1;
				left  = len;
				fold(BYTE_START);
				owe(BYTE_START, 1'b0, 1'b0);
				fold(cmd);
				owe(cmd, 1'b0, 1'b0);
				fold({len[7:0]});
				owe(len[7:0], 1'b0, 1'b0);
				fold({6'd0, len[9:8]});
				owe({6'd0, len[9:8]}, 1'b0, 1'b0);
				if (len == 0)
					close_packet();
			end else if (!open || left == 0) begin
				owe(8'h00, 1'b0, 1'b1);
			end else begin
				fold(dat);
				owe(dat, 1'b0, 1'b0);
				left = left - 10'd1;
				if (left == 0)
					close_packet();
			end
			tail = owed_bytes.pop_back();
			tail.last = 1'b1;
			owed_bytes.push_back(tail);
		endfunction

		function void compare(string what, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
				errors++;
			end
		endfunction

		// Called on every accepted output transfer
		function void check_byte(logic [7:0] value, logic pkt_end, logic last, logic err);
			frame_byte_t want;
			if (owed_bytes.size() == 0) begin
				$display("%0t: unexpected output byte, expected none, actual %h end %b last %b err %b",
					$time, value, pkt_end, last, err);
				errors++;
				return;
			end
			want = owed_bytes.pop_front();
			compare("out_byte", want.value, value);
			compare("packet_end", {7'd0, want.pkt_end}, {7'd0, pkt_end});
			compare("run_last", {7'd0, want.last}, {7'd0, last});
			compare("frame_error", {7'd0, want.err}, {7'd0, err});
		endfunction

		function int pending();
			return owed_bytes.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic       op;
	logic [7:0] command;
	logic [9:0] length;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       packet_end;
	logic       run_last;
	logic       frame_error;

	frame_tracker tracker = new();

	// Idling controls, changed per phase by the stimulus
	int unsigned gap_pct;
	int unsigned stall_pct;
	bit          hold_req;
	int          items_sent;
	int          quiet_cycles;

	bootloader_packet_framer_top #(
		.MAX_PAYLOAD(MAX_LEN)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.command     (command),
		.length      (length),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.packet_end  (packet_end),
		.run_last    (run_last),
		.frame_error (frame_error)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Monitors: both sample the pre-edge values, so the order of processes
	// within the clock edge does not matter.
	always @(posedge clk) begin
		if (in_valid && in_ready)
			tracker.take_item(frame_op_t'(op), command, length, data_byte);
		if (out_valid && out_ready)
			tracker.check_byte(out_byte, packet_end, run_last, frame_error);
	end

	// Watchdog: any transfer on any channel counts as progress
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request so that
	// the block backs up and drops in_ready.
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offers one item and returns at the edge where it is transferred. Valid
	// is left high so a back-to-back item needs no second assignment.
	task automatic push_item(frame_op_t o, logic [7:0] cmd, logic [9:0] len,
			logic [7:0] dat);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= o;
		command   <= cmd;
		length    <= len;
		data_byte <= dat;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Sender stops offering until every owed byte has left the block
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Only called with the block idle
	task automatic write_mode(bit m);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.mode = m;
	endtask

	// Mostly well-formed packets with random content; now and then a stray
	// data byte, a packet cut short by the next begin, or an oversized header.
	task automatic random_traffic(int target);
		int unsigned pick;
		int unsigned len;
		int unsigned sent;
		while (items_sent < target) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				push_item(OP_DATA, 8'($urandom), 10'($urandom), 8'($urandom));
			end else begin
				pick = $urandom_range(0, 15);
				if (pick < 2)
					len = 0;
				else if (pick < 13)
					len = $urandom_range(1, 6);
				else if (pick < 15)
					len = $urandom_range(7, 40);
				else
					len = $urandom_range(MAX_LEN + 1, 1023);
				push_item(OP_BEGIN, 8'($urandom), 10'(len), 8'($urandom));
				sent = 0;
				while (sent < len && sent < 40) begin
					// occasionally cut the packet short
					if ($urandom_range(0, 24) == 0)
						break;
					push_item(OP_DATA, 8'($urandom), 10'($urandom), 8'($urandom));
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		cfg_valid  <= 1'b0;
		cfg_data   <= 1'b0;
		in_valid   <= 1'b0;
		op         <= OP_BEGIN;
		command    <= '0;
		length     <= '0;
		data_byte  <= '0;
		gap_pct    = 0;
		stall_pct  = 0;
		hold_req   = 1'b0;
		items_sent = 0;
		tracker.mode = MODE_SUM;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: sum checksum first
		write_mode(MODE_SUM);
		push_item(OP_DATA, 8'h00, 10'd0, 8'hFF);     // stray byte, nothing open
		push_item(OP_BEGIN, 8'h00, 10'd0, 8'h00);    // empty packet, all seven bytes
		push_item(OP_BEGIN, 8'hFF, 10'd1, 8'h00);
		push_item(OP_DATA, 8'hFF, 10'h3FF, 8'h00);   // closes the packet
		push_item(OP_DATA, 8'h00, 10'd0, 8'h55);     // stray after close
		push_item(OP_BEGIN, 8'hA5, 10'd3, 8'h00);
		push_item(OP_DATA, 8'h00, 10'd0, 8'hAA);
		push_item(OP_BEGIN, 8'h5A, 10'd2, 8'h00);    // drops the open packet
		push_item(OP_DATA, 8'h00, 10'd0, 8'h01);
		push_item(OP_DATA, 8'h00, 10'd0, 8'hFE);
		push_item(OP_BEGIN, 8'h3C, 10'h3FF, 8'h00);  // clipped to the maximum
		push_item(OP_DATA, 8'h00, 10'd0, 8'h80);
		push_item(OP_BEGIN, 8'hC3, 10'd513, 8'h00);
		push_item(OP_BEGIN, 8'h7E, 10'(MAX_LEN), 8'h00);
		// packet begun under the sum, finished under the CRC
		push_item(OP_BEGIN, 8'h11, 10'd2, 8'h00);
		push_item(OP_DATA, 8'h00, 10'd0, 8'h22);
		drain();
		write_mode(MODE_CRC);
		push_item(OP_DATA, 8'h00, 10'd0, 8'h33);
		push_item(OP_BEGIN, 8'h00, 10'd0, 8'h00);
		push_item(OP_BEGIN, 8'h31, 10'd1, 8'h00);
		push_item(OP_DATA, 8'h00, 10'd0, 8'hC4);
		push_item(OP_DATA, 8'h00, 10'd0, 8'h7F);
		// and the other way round
		push_item(OP_BEGIN, 8'h96, 10'd2, 8'h00);
		push_item(OP_DATA, 8'h00, 10'd0, 8'h69);
		drain();
		write_mode(MODE_SUM);
		push_item(OP_DATA, 8'h00, 10'd0, 8'hE1);
		drain();

		// Random phase 1: CRC, light idling on both sides
		write_mode(MODE_CRC);
		gap_pct   = 15;
		stall_pct = 15;
		random_traffic(items_sent + 35);
		drain();

		// Phase 2: sum, long receiver hold-off while items keep coming
		write_mode(MODE_SUM);
		gap_pct   = 0;
		stall_pct = 10;
		hold_req  = 1'b1;
		random_traffic(items_sent + 35);
		drain();

		// Phase 3: random mode, heavy idling
		write_mode(1'($urandom));
		gap_pct   = 30;
		stall_pct = 30;
		random_traffic(items_sent + 35);
		drain();

		// Phase 4: random mode, no idling at all
		write_mode(1'($urandom));
		gap_pct   = 0;
		stall_pct = 0;
		random_traffic(items_sent + 35);

		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		if (tracker.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: filelist.f
rtl/bpf_pkg.sv
rtl/bpf_chk.sv
rtl/bootloader_packet_framer_top.sv
dv/tb_top.sv
